// File: hdl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared constants and types for the paging translation unit
// Address split, TLB entry layout and control/status groups.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int NUM_FRAMES  = 128;
  localparam int NUM_PAGES   = 256;
  localparam int OFFSET_BITS = 8;

  localparam int ADDR_W  = 16;
  localparam int PA_W    = 15;
  localparam int CNT_W   = 16;
  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int FIU_W   = $clog2(NUM_FRAMES + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic   valid;
    page_t  page;
    frame_t frame;
  } tlb_entry_t;

  // insert shifts the chain; kill drops every entry naming kill_page
  typedef struct packed {
    logic   insert;
    page_t  ins_page;
    frame_t ins_frame;
    logic   kill;
    page_t  kill_page;
  } tlb_cmd_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlb_res_t;

endpackage

// File: hdl/tpt_if.sv
// ----------------------------------------------------------------------------
// tpt_if: valid/ready channels of the paging translation unit
// Address channel in, translation result channel out.
// ----------------------------------------------------------------------------
interface tpt_in_if;
  logic                       valid;
  logic                       ready;
  logic [tpt_pkg::ADDR_W-1:0] vaddr;

  modport source (output valid, output vaddr, input ready);
  modport sink   (input valid, input vaddr, output ready);
endinterface

interface tpt_out_if;
  logic                      valid;
  logic                      ready;
  logic [tpt_pkg::PA_W-1:0]  paddr;
  logic                      tlb_hit;
  logic                      page_fault;
  logic [tpt_pkg::CNT_W-1:0] hit_total;
  logic [tpt_pkg::CNT_W-1:0] fault_total;

  modport source (output valid, output paddr, output tlb_hit, output page_fault,
                  output hit_total, output fault_total, input ready);
  modport sink   (input valid, input paddr, input tlb_hit, input page_fault,
                  input hit_total, input fault_total, output ready);
endinterface

// File: hdl/tpt_ram.sv
// ----------------------------------------------------------------------------
// tpt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tpt_tlb_cell.sv
// ----------------------------------------------------------------------------
// tpt_tlb_cell: one TLB entry of the shifting entry chain
// Compares against the lookup page, drops on a kill match, and takes the
// neighbor's entry when a new mapping is shifted in.
// ----------------------------------------------------------------------------
module tpt_tlb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tpt_pkg::tlb_cmd_t   cmd,
  input  tpt_pkg::page_t      lookup_page,
  input  tpt_pkg::tlb_entry_t prev_entry,
  output tpt_pkg::tlb_entry_t next_entry,
  output logic                match,
  output tpt_pkg::frame_t     hit_frame
);

  tpt_pkg::tlb_entry_t entry_r;
  tpt_pkg::tlb_entry_t kept;

  always_comb begin
    kept = entry_r;
    if (cmd.kill && entry_r.page == cmd.kill_page) begin
      kept.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (cmd.insert) begin
      entry_r <= prev_entry;
    end else begin
      entry_r <= kept;
    end
  end

  assign next_entry = kept;
  assign match      = entry_r.valid && (entry_r.page == lookup_page);
  assign hit_frame  = match ? entry_r.frame : '0;

endmodule

// File: hdl/tpt_tlb.sv
// ----------------------------------------------------------------------------
// tpt_tlb: TLB built as a chain of entry cells
// New mappings enter at cell 0 and age toward the end; the oldest falls out.
// ----------------------------------------------------------------------------
module tpt_tlb (
  input  logic              clk,
  input  logic              rst_n,
  input  tpt_pkg::tlb_cmd_t cmd,
  input  tpt_pkg::page_t    lookup_page,
  output tpt_pkg::tlb_res_t res
);

  tpt_pkg::tlb_entry_t            chain_in  [tpt_pkg::TLB_ENTRIES];
  tpt_pkg::tlb_entry_t            chain_out [tpt_pkg::TLB_ENTRIES];
  tpt_pkg::frame_t                hit_frame [tpt_pkg::TLB_ENTRIES];
  logic [tpt_pkg::TLB_ENTRIES-1:0] match;

  assign chain_in[0] = '{valid: 1'b1, page: cmd.ins_page, frame: cmd.ins_frame};

  for (genvar g = 0; g < tpt_pkg::TLB_ENTRIES; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    tpt_tlb_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .lookup_page (lookup_page),
      .prev_entry  (chain_in[g]),
      .next_entry  (chain_out[g]),
      .match       (match[g]),
      .hit_frame   (hit_frame[g])
    );
  end

  // at most one valid entry per page, so the frames can be or-ed together
  always_comb begin
    res.hit   = |match;
    res.frame = '0;
    for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++) begin
      res.frame = res.frame | hit_frame[i];
    end
  end

endmodule

// File: hdl/tlb_page_translation_fifo_unit.sv
// ----------------------------------------------------------------------------
// tlb_page_translation_fifo_unit: paging MMU with FIFO TLB and frame reuse
//
// in_ch carries one 16-bit logical address per word; out_ch returns one
// translation word per address: physical address, TLB hit and page fault
// flags, and saturating hit and fault totals after that access.
// For each word, the accepting edge reads the page table frame RAM
// and the frame owner RAM, the following cycle does the TLB cell compare,
// picks the frame, updates table, owners and TLB, and loads the result
// register; out_ch.valid rises as that register is loaded. A new address is
// accepted only once that lookup is done and while the receiver keeps up.
// On a fault, free frames go out in ascending order; once all are used the
// oldest frame is reclaimed and its page dropped from table and TLB.
// Reset clears TLB, table valid bits, frame counters and hit/fault totals;
// no clearing pass is needed. When out_ch stalls the result word is held and
// in_ch.ready stays low until the word is taken.
// ----------------------------------------------------------------------------
module tlb_page_translation_fifo_unit (
  input  logic       clk,
  input  logic       rst_n,
  tpt_in_if.sink     in_ch,
  tpt_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t                          state_r;
  logic [tpt_pkg::ADDR_W-1:0]      addr_r;
  logic                            out_valid_r;
  logic [tpt_pkg::PA_W-1:0]        pa_r;
  logic                            hit_r;
  logic                            fault_r;
  logic [tpt_pkg::CNT_W-1:0]       hit_cnt_r;
  logic [tpt_pkg::CNT_W-1:0]       fault_cnt_r;
  logic [tpt_pkg::FIU_W-1:0]       fiu_r;
  tpt_pkg::frame_t                 victim_r;
  logic [tpt_pkg::NUM_PAGES-1:0]   table_valid_r;

  logic                            accept;
  logic                            look;
  tpt_pkg::page_t                  in_page;
  tpt_pkg::page_t                  page;
  tpt_pkg::frame_t                 table_frame;
  tpt_pkg::page_t                  owner_page;
  tpt_pkg::tlb_cmd_t               tlb_cmd;
  tpt_pkg::tlb_res_t               tlb_res;
  logic                            fault;
  logic                            free_avail;
  tpt_pkg::frame_t                 frame_sel;

  assign accept  = in_ch.valid && in_ch.ready;
  assign look    = (state_r == ST_LOOK);
  assign in_page = in_ch.vaddr[tpt_pkg::OFFSET_BITS +: tpt_pkg::PAGE_W];
  assign page    = addr_r[tpt_pkg::OFFSET_BITS +: tpt_pkg::PAGE_W];

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);

  // page table frames and frame owners
  tpt_ram #(.WIDTH(tpt_pkg::FRAME_W), .DEPTH(tpt_pkg::NUM_PAGES)) u_table_ram (
    .clk   (clk),
    .we    (look && fault),
    .waddr (page),
    .wdata (frame_sel),
    .raddr (in_page),
    .rdata (table_frame)
  );

  tpt_ram #(.WIDTH(tpt_pkg::PAGE_W), .DEPTH(tpt_pkg::NUM_FRAMES)) u_owner_ram (
    .clk   (clk),
    .we    (look && fault),
    .waddr (frame_sel),
    .wdata (page),
    .raddr (victim_r),
    .rdata (owner_page)
  );

  tpt_tlb u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (tlb_cmd),
    .lookup_page (page),
    .res         (tlb_res)
  );

  always_comb begin
    free_avail = (fiu_r < tpt_pkg::FIU_W'(tpt_pkg::NUM_FRAMES));
    fault      = !tlb_res.hit && !table_valid_r[page];
    if (tlb_res.hit) begin
      frame_sel = tlb_res.frame;
    end else if (!fault) begin
      frame_sel = table_frame;
    end else if (free_avail) begin
      frame_sel = fiu_r[tpt_pkg::FRAME_W-1:0];
    end else begin
      frame_sel = victim_r;
    end
    tlb_cmd.insert    = look && !tlb_res.hit;
    tlb_cmd.ins_page  = page;
    tlb_cmd.ins_frame = frame_sel;
    tlb_cmd.kill      = look && fault && !free_avail;
    tlb_cmd.kill_page = owner_page;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      hit_cnt_r     <= '0;
      fault_cnt_r   <= '0;
      fiu_r         <= '0;
      victim_r      <= '0;
      table_valid_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          if (tlb_res.hit && hit_cnt_r != tpt_pkg::CNT_MAX) begin
            hit_cnt_r <= hit_cnt_r + 1'b1;
          end
          if (fault) begin
            if (fault_cnt_r != tpt_pkg::CNT_MAX) begin
              fault_cnt_r <= fault_cnt_r + 1'b1;
            end
            if (free_avail) begin
              fiu_r <= fiu_r + 1'b1;
            end else begin
              table_valid_r[owner_page] <= 1'b0;
              victim_r <= (victim_r == tpt_pkg::FRAME_W'(tpt_pkg::NUM_FRAMES - 1)) ?
                          '0 : victim_r + 1'b1;
            end
            table_valid_r[page] <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_ch.vaddr;
    end
    if (look) begin
      pa_r    <= tpt_pkg::PA_W'({frame_sel, addr_r[tpt_pkg::OFFSET_BITS-1:0]});
      hit_r   <= tlb_res.hit;
      fault_r <= fault;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.paddr       = pa_r;
  assign out_ch.tlb_hit     = hit_r;
  assign out_ch.page_fault  = fault_r;
  assign out_ch.hit_total   = hit_cnt_r;
  assign out_ch.fault_total = fault_cnt_r;

  // the result register is free whenever a lookup finishes
  a_look_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    look |-> !out_valid_r)
    else $error("lookup finished with result register still full");

  a_look_fills: assert property (@(posedge clk) disable iff (!rst_n)
    look |=> out_valid_r && state_r == ST_IDLE)
    else $error("lookup did not produce a result word");

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fiu_r <= tpt_pkg::FIU_W'(tpt_pkg::NUM_FRAMES))
    else $error("frames in use above frame count");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fault_cnt_r >= $past(fault_cnt_r))
    else $error("fault total went backwards");

  a_victim_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    victim_r != '0 |-> fiu_r == tpt_pkg::FIU_W'(tpt_pkg::NUM_FRAMES))
    else $error("frame reclaimed before all frames were handed out");

endmodule
